// ===== src/i2cram_pkg.sv =====
// i2cram_pkg: shared types and register indexes of the i2c register access master
// no dependencies; imported by i2cram_seq and i2c_register_access_master
`default_nettype none

package i2cram_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TARGET_ADDR = 2'd0;
  localparam logic [1:0] CFG_HALF        = 2'd1;
  localparam logic [1:0] CFG_SS          = 2'd2;
  localparam logic [1:0] CFG_ACK_TO      = 2'd3;

  // reset values of the configuration registers
  localparam logic [6:0] TARGET_ADDR_RST = 7'd72;
  localparam logic [7:0] HALF_RST        = 8'd2;
  localparam logic [7:0] SS_RST          = 8'd4;
  localparam logic [7:0] ACK_TO_RST      = 8'd20;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [6:0] target_addr;
    logic [7:0] half_ticks;
    logic [7:0] ss_ticks;
    logic [7:0] ack_to_ticks;
  } cfg_t;

  // one tick request
  typedef struct packed {
    logic        go;
    logic        opcode;
    logic [7:0]  reg_offset;
    logic [15:0] write_data;
    logic        sda_in;
  } item_t;

  // one tick result
  typedef struct packed {
    logic        scl;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        nack_error;
    logic [15:0] read_value;
  } res_t;

endpackage

`default_nettype wire

// ===== src/i2c_register_access_master.sv =====
// i2c_register_access_master: top level with request register, result register
// and configuration registers; depends on i2cram_pkg and i2cram_seq
//
// channel  direction  handshake             payload
// in_      request    in_valid / in_stall   go, opcode, reg_offset, write_data, sda_in
// out_     result     out_valid / out_stall scl, sda_pull_low, busy_res, done_res,
//                                           nack_error, read_value
// cfg_     write      cfg_we                cfg_index, cfg_wdata
//
// one request per clock cycle unless the result stalls; each gives exactly one result
// throughput is set by the single sequencer step between request and result registers
// synchronous active-low reset empties both registers and idles the sequencer
// a stalled result holds; a new request is still taken while the request register
// drains into a free result slot
`default_nettype none

module i2c_register_access_master
  import i2cram_pkg::*;
#(
  parameter int REG_DATA_BYTES = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_go,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_reg_offset,
  input  wire logic [15:0] in_write_data,
  input  wire logic        in_sda_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_scl,
  output logic             out_sda_pull_low,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic             out_nack_error,
  output logic [15:0]      out_read_value,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  cfg_t  cfg_r;
  logic  in_v_r;
  item_t item_r;
  logic  out_v_r;
  res_t  res_r;
  res_t  res;
  logic  step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_addr  <= TARGET_ADDR_RST;
      cfg_r.half_ticks   <= HALF_RST;
      cfg_r.ss_ticks     <= SS_RST;
      cfg_r.ack_to_ticks <= ACK_TO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_ADDR: cfg_r.target_addr  <= cfg_wdata[6:0];
        CFG_HALF:        cfg_r.half_ticks   <= cfg_wdata;
        CFG_SS:          cfg_r.ss_ticks     <= cfg_wdata;
        CFG_ACK_TO:      cfg_r.ack_to_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // handshake: the held request steps when the result slot is free or draining
  assign step     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !step;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.go         <= in_go;
      item_r.opcode     <= in_opcode;
      item_r.reg_offset <= in_reg_offset;
      item_r.write_data <= in_write_data;
      item_r.sda_in     <= in_sda_in;
    end
  end

  i2cram_seq #(
    .REG_DATA_BYTES (REG_DATA_BYTES)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_scl          = res_r.scl;
  assign out_sda_pull_low = res_r.sda_pull_low;
  assign out_busy_res     = res_r.busy_res;
  assign out_done_res     = res_r.done_res;
  assign out_nack_error   = res_r.nack_error;
  assign out_read_value   = res_r.read_value;

endmodule

`default_nettype wire

// ===== src/i2cram_seq.sv =====
// i2cram_seq: bus phase sequencer, one tick of bus activity per step
// depends on i2cram_pkg (cfg_t, item_t, res_t)
`default_nettype none

module i2cram_seq
  import i2cram_pkg::*;
#(
  parameter int REG_DATA_BYTES = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  // phase codes
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_START_SETUP = 4'd1;
  localparam logic [3:0] PH_START_HOLD  = 4'd2;
  localparam logic [3:0] PH_RS_PREP     = 4'd3;
  localparam logic [3:0] PH_TX_LOW      = 4'd4;
  localparam logic [3:0] PH_TX_HIGH     = 4'd5;
  localparam logic [3:0] PH_ACK_LOW     = 4'd6;
  localparam logic [3:0] PH_ACK_HIGH    = 4'd7;
  localparam logic [3:0] PH_RX_LOW      = 4'd8;
  localparam logic [3:0] PH_RX_HIGH     = 4'd9;
  localparam logic [3:0] PH_MACK_LOW    = 4'd10;
  localparam logic [3:0] PH_MACK_HIGH   = 4'd11;
  localparam logic [3:0] PH_STOP_LOW    = 4'd12;
  localparam logic [3:0] PH_STOP_HIGH   = 4'd13;
  localparam logic [3:0] PH_STOP_REL    = 4'd14;

  localparam logic [2:0] LAST_RX   = 3'(2 + REG_DATA_BYTES);
  localparam logic [3:0] LAST_BYTE = 4'(2 + REG_DATA_BYTES);
  localparam logic [2:0] DATA_N    = 3'(REG_DATA_BYTES);
  localparam logic [1:0] DATA_TOP  = 2'(REG_DATA_BYTES - 1);

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] rshift_r, rshift_nxt;
  logic        op_r, op_nxt;
  logic [7:0]  offset_r, offset_nxt;
  logic [15:0] value_r, value_nxt;
  logic [7:0]  to_r, to_nxt;
  logic        err_r, err_nxt;

  // byte to send for a given position in the transfer
  function automatic logic [7:0] byte_for(input logic [2:0] idx, input logic op,
                                          input logic [6:0] addr, input logic [7:0] offset,
                                          input logic [15:0] value);
    logic [31:0] wide;
    logic [2:0]  k;
    logic [1:0]  j;
    wide = {16'd0, value};
    k    = idx - 3'd2;
    j    = DATA_TOP - k[1:0];
    byte_for = 8'd0;
    if (idx == 3'd0) begin
      byte_for = {addr, 1'b0};
    end else if (idx == 3'd1) begin
      byte_for = offset;
    end else if (op) begin
      byte_for = {addr, 1'b1};
    end else if (k < DATA_N) begin
      byte_for = wide[8*j +: 8];
    end
  endfunction

  // next state and line levels for one tick
  always_comb begin
    logic [3:0] ph;
    logic [7:0] len;
    logic [7:0] to_lim;
    logic       over;
    logic [3:0] next_byte;
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    byte_nxt   = byte_r;
    shift_nxt  = shift_r;
    rshift_nxt = rshift_r;
    op_nxt     = op_r;
    offset_nxt = offset_r;
    value_nxt  = value_r;
    to_nxt     = to_r;
    err_nxt    = err_r;
    res        = '0;
    res.scl    = 1'b1;
    ph         = phase_r;

    // go is taken only while idle and starts the setup on the same tick
    if (phase_r == PH_IDLE && item.go) begin
      op_nxt     = item.opcode;
      offset_nxt = item.reg_offset;
      value_nxt  = item.write_data;
      err_nxt    = 1'b0;
      tick_nxt   = 8'd0;
      byte_nxt   = 3'd0;
      bit_nxt    = 3'd0;
      to_nxt     = 8'd0;
      ph         = PH_START_SETUP;
    end
    phase_nxt    = ph;
    res.busy_res = (ph != PH_IDLE);

    // phase length and end of phase
    if (ph == PH_START_SETUP || ph == PH_START_HOLD || ph == PH_STOP_LOW ||
        ph == PH_STOP_HIGH || ph == PH_STOP_REL) begin
      len = cfg.ss_ticks;
    end else begin
      len = cfg.half_ticks;
    end
    if (len == 8'd0) begin
      len = 8'd1;
    end
    over   = ({1'b0, tick_nxt} + 9'd1) >= {1'b0, len};
    to_lim = (cfg.ack_to_ticks == 8'd0) ? 8'd1 : cfg.ack_to_ticks;
    next_byte = {1'b0, byte_r} + 4'd1;

    unique case (ph)
      PH_IDLE: begin
      end
      PH_START_SETUP: begin
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          phase_nxt = PH_START_HOLD;
        end
      end
      PH_START_HOLD: begin
        res.sda_pull_low = 1'b1;
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          shift_nxt = byte_for(byte_nxt, op_nxt, cfg.target_addr, offset_nxt, value_nxt);
          bit_nxt   = 3'd0;
          phase_nxt = PH_TX_LOW;
        end
      end
      PH_RS_PREP: begin
        res.scl  = 1'b0;
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          phase_nxt = PH_START_SETUP;
        end
      end
      PH_TX_LOW, PH_TX_HIGH: begin
        res.scl          = (ph == PH_TX_HIGH);
        res.sda_pull_low = ~shift_r[7];
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          if (ph == PH_TX_LOW) begin
            phase_nxt = PH_TX_HIGH;
          end else if (bit_r == 3'd7) begin
            phase_nxt = PH_ACK_LOW;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = PH_TX_LOW;
          end
        end
      end
      PH_ACK_LOW: begin
        res.scl  = 1'b0;
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          to_nxt    = 8'd0;
          phase_nxt = PH_ACK_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        // poll the acknowledge while scl stays high
        tick_nxt = 8'd0;
        if (!item.sda_in) begin
          if (!op_r) begin
            byte_nxt = next_byte[2:0];
            if (next_byte < LAST_BYTE) begin
              shift_nxt = byte_for(next_byte[2:0], op_r, cfg.target_addr, offset_r, value_r);
              bit_nxt   = 3'd0;
              phase_nxt = PH_TX_LOW;
            end else begin
              phase_nxt = PH_STOP_LOW;
            end
          end else if (next_byte < 4'd2) begin
            byte_nxt  = next_byte[2:0];
            shift_nxt = byte_for(next_byte[2:0], op_r, cfg.target_addr, offset_r, value_r);
            bit_nxt   = 3'd0;
            phase_nxt = PH_TX_LOW;
          end else if (next_byte == 4'd2) begin
            byte_nxt  = 3'd2;
            phase_nxt = PH_RS_PREP;
          end else begin
            byte_nxt  = 3'd3;
            bit_nxt   = 3'd0;
            phase_nxt = PH_RX_LOW;
          end
        end else begin
          to_nxt = to_r + 8'd1;
          if (to_nxt >= to_lim) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_STOP_LOW;
          end
        end
      end
      PH_RX_LOW: begin
        res.scl  = 1'b0;
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          phase_nxt = PH_RX_HIGH;
        end
      end
      PH_RX_HIGH: begin
        // sample on the last tick of the high phase
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          rshift_nxt = {rshift_r[14:0], item.sda_in};
          if (bit_r == 3'd7) begin
            phase_nxt = PH_MACK_LOW;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = PH_RX_LOW;
          end
        end
      end
      PH_MACK_LOW, PH_MACK_HIGH: begin
        res.scl          = (ph == PH_MACK_HIGH);
        res.sda_pull_low = (byte_r < LAST_RX);
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          if (ph == PH_MACK_LOW) begin
            phase_nxt = PH_MACK_HIGH;
          end else if (byte_r >= LAST_RX) begin
            phase_nxt = PH_STOP_LOW;
          end else begin
            byte_nxt  = byte_r + 3'd1;
            bit_nxt   = 3'd0;
            phase_nxt = PH_RX_LOW;
          end
        end
      end
      PH_STOP_LOW: begin
        res.scl          = 1'b0;
        res.sda_pull_low = 1'b1;
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          phase_nxt = PH_STOP_HIGH;
        end
      end
      PH_STOP_HIGH: begin
        res.sda_pull_low = 1'b1;
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          phase_nxt = PH_STOP_REL;
        end
      end
      PH_STOP_REL: begin
        tick_nxt = over ? 8'd0 : tick_nxt + 8'd1;
        if (over) begin
          res.done_res   = 1'b1;
          res.nack_error = err_nxt;
          phase_nxt      = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = 8'd0;
      end
    endcase
    res.read_value = rshift_nxt;
  end

  // sequencer state, advanced once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= 8'd0;
      bit_r    <= 3'd0;
      byte_r   <= 3'd0;
      shift_r  <= 8'd0;
      rshift_r <= 16'd0;
      op_r     <= 1'b0;
      offset_r <= 8'd0;
      value_r  <= 16'd0;
      to_r     <= 8'd0;
      err_r    <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      byte_r   <= byte_nxt;
      shift_r  <= shift_nxt;
      rshift_r <= rshift_nxt;
      op_r     <= op_nxt;
      offset_r <= offset_nxt;
      value_r  <= value_nxt;
      to_r     <= to_nxt;
      err_r    <= err_nxt;
    end
  end

  // a finished transaction always returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == PH_IDLE)
    else $error("sequencer not idle after done");

  // the tick counter is clear whenever the bus is idle
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_r == 8'd0)
    else $error("tick counter not clear while idle");

  // a write transaction never disturbs the read shift register
  a_write_rshift: assert property (@(posedge clk) disable iff (!rst_n)
    step && !op_r && phase_r != PH_IDLE |=> $stable(rshift_r))
    else $error("read value changed during a write");

endmodule

`default_nettype wire
